/* rtl/dmr_pkg.sv */
// dmr_pkg: shared types, constants and the base table for the 63-bit primality tester
// no dependencies
package dmr_pkg;

	localparam int CW = 63;
	localparam int BIT_CNT_W = 6;
	localparam int BASE_IDX_W = 4;

	localparam logic [CW-1:0] LIM_B3  = 63'd1373653;
	localparam logic [CW-1:0] LIM_B5  = 63'd25326001;
	localparam logic [CW-1:0] PSP_B7  = 63'd3215031751;
	localparam logic [CW-1:0] LIM_B7  = 63'd25000000000;
	localparam logic [CW-1:0] LIM_B11 = 63'd2152302898747;
	localparam logic [CW-1:0] LIM_B13 = 63'd3474749660383;
	localparam logic [CW-1:0] LIM_B17 = 63'd341550071728321;

	localparam logic [BASE_IDX_W-1:0] LAST_BASE = 4'd11;

	typedef enum logic [3:0] {
		S_IDLE,
		S_SPLIT,
		S_BASE,
		S_RED,
		S_SQ,
		S_SQ_W,
		S_ML,
		S_ML_W,
		S_CHECK,
		S_SQR,
		S_SQR_W,
		S_THRESH,
		S_DONE
	} state_t;

	function automatic logic [5:0] base_of(input logic [BASE_IDX_W-1:0] k);
		logic [5:0] b;
		case (k)
			4'd0: b = 6'd2;
			4'd1: b = 6'd3;
			4'd2: b = 6'd5;
			4'd3: b = 6'd7;
			4'd4: b = 6'd11;
			4'd5: b = 6'd13;
			4'd6: b = 6'd17;
			4'd7: b = 6'd19;
			4'd8: b = 6'd23;
			4'd9: b = 6'd29;
			4'd10: b = 6'd31;
			4'd11: b = 6'd37;
			default: b = 6'd2;
		endcase
		return b;
	endfunction

endpackage

/* rtl/dmr_mulmod.sv */
// dmr_mulmod: bit-serial modular multiplier, msb first, a doubling phase and an add phase per bit
// depends on dmr_pkg
module dmr_mulmod
	import dmr_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [CW-1:0] a,
	input  logic [CW-1:0] b,
	input  logic [CW-1:0] n,
	output logic [CW-1:0] result,
	output logic          done
);

	logic [CW-1:0]        acc_q, a_q, b_q, n_q;
	logic [BIT_CNT_W-1:0] cnt_q;
	logic                 ph_q, run_q, done_q;
	logic [CW:0]          dbl, dbl_r, add, add_r;

	always_comb begin
		dbl   = {acc_q, 1'b0};
		dbl_r = (dbl >= {1'b0, n_q}) ? dbl - {1'b0, n_q} : dbl;
		add   = {1'b0, acc_q} + {1'b0, a_q};
		add_r = (add >= {1'b0, n_q}) ? add - {1'b0, n_q} : add;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			ph_q   <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				ph_q  <= 1'b0;
				cnt_q <= '0;
			end else if (run_q) begin
				ph_q <= ~ph_q;
				if (ph_q) begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == BIT_CNT_W'(CW - 1)) begin
						run_q  <= 1'b0;
						done_q <= 1'b1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= '0;
			a_q   <= a;
			b_q   <= b;
			n_q   <= n;
		end else if (run_q) begin
			if (!ph_q) begin
				acc_q <= dbl_r[CW-1:0];
			end else begin
				if (b_q[CW-1])
					acc_q <= add_r[CW-1:0];
				b_q <= {b_q[CW-2:0], 1'b0};
			end
		end
	end

	assign result = acc_q;
	assign done   = done_q;

`ifndef SYNTHESIS
	a_done_lt_n: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> (acc_q < n_q)) else $error("mulmod result not reduced");
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q) else $error("mulmod done longer than one cycle");
	a_run_done: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !run_q) else $error("mulmod done while running");
`endif

endmodule

/* rtl/deterministic_miller_rabin_64.sv */
// deterministic_miller_rabin_64: top level, sequencer for miller-rabin rounds
// depends on dmr_pkg and dmr_mulmod
//
// channel  dir  handshake              payload
// in       in   in_valid / in_stall    candidate [62:0]
// out      out  out_valid / out_stall  prime_flag
//
// one request at a time; each modular multiply steps through start, a doubling and an add phase per bit, then done
// a base round takes 63 squarings plus one multiply per set bit of d plus up to s-1
// squarings, and up to 12 bases are tried in the worst case
// candidates below 4 skip the rounds and go straight from idle to done
// reset clears the state register and out_valid; a result held by out_stall does not block the next request
module deterministic_miller_rabin_64
	import dmr_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	input  logic [CW-1:0] candidate,
	output logic          out_valid,
	input  logic          out_stall,
	output logic          prime_flag
);

	state_t state_q, state_nx;

	logic [CW-1:0]         n_q, nm1_q, d_q, dsh_q, b_q, x_q;
	logic [BIT_CNT_W-1:0]  s_q, i_q, bit_q;
	logic [BASE_IDX_W-1:0] k_q;
	logic                  res_q, out_valid_q, prime_flag_q;

	logic          mul_start, mul_done;
	logic [CW-1:0] mul_b, mul_res;
	logic          in_fire, out_free, small_n, last_bit;
	logic          chk_pass, chk_more, sqr_pass, sqr_more;
	logic          th_prime, th_fail;

	dmr_mulmod u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (x_q),
		.b      (mul_b),
		.n      (n_q),
		.result (mul_res),
		.done   (mul_done)
	);

	always_comb begin
		in_fire  = in_valid && !in_stall;
		out_free = !out_valid_q || !out_stall;
		small_n  = (candidate < 63'd4);
		last_bit = (bit_q == BIT_CNT_W'(CW - 1));
		chk_pass = (x_q == 63'd1) || (x_q == nm1_q);
		chk_more = (s_q > 6'd1);
		sqr_pass = (mul_res == nm1_q);
		sqr_more = ((i_q + 1'b1) < s_q);
		th_prime = 1'b0;
		th_fail  = 1'b0;
		case (k_q)
			4'd1: th_prime = (n_q < LIM_B3);
			4'd2: th_prime = (n_q < LIM_B5);
			4'd3: begin
				th_fail  = (n_q == PSP_B7);
				th_prime = (n_q < LIM_B7);
			end
			4'd4: th_prime = (n_q < LIM_B11);
			4'd5: th_prime = (n_q < LIM_B13);
			4'd6: th_prime = (n_q < LIM_B17);
			LAST_BASE: th_prime = 1'b1;
			default: th_prime = 1'b0;
		endcase
	end

	// next state
	always_comb begin
		state_nx = state_q;
		case (state_q)
			S_IDLE:   if (in_fire) state_nx = small_n ? S_DONE : S_SPLIT;
			S_SPLIT:  if (d_q[0]) state_nx = S_BASE;
			S_BASE:   state_nx = S_RED;
			S_RED:    if (b_q < n_q) state_nx = S_SQ;
			S_SQ:     state_nx = S_SQ_W;
			S_SQ_W: begin
				if (mul_done) begin
					if (dsh_q[CW-1]) state_nx = S_ML;
					else if (last_bit) state_nx = S_CHECK;
					else state_nx = S_SQ;
				end
			end
			S_ML:     state_nx = S_ML_W;
			S_ML_W: begin
				if (mul_done) state_nx = last_bit ? S_CHECK : S_SQ;
			end
			S_CHECK: begin
				if (chk_pass) state_nx = S_THRESH;
				else if (chk_more) state_nx = S_SQR;
				else state_nx = S_DONE;
			end
			S_SQR:    state_nx = S_SQR_W;
			S_SQR_W: begin
				if (mul_done) begin
					if (sqr_pass) state_nx = S_THRESH;
					else if (sqr_more) state_nx = S_SQR;
					else state_nx = S_DONE;
				end
			end
			S_THRESH: state_nx = (th_fail || th_prime) ? S_DONE : S_BASE;
			S_DONE:   if (out_free) state_nx = S_IDLE;
			default:  state_nx = S_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		in_stall  = (state_q != S_IDLE);
		mul_start = (state_q == S_SQ) || (state_q == S_ML) || (state_q == S_SQR);
		mul_b     = (state_q == S_ML) ? b_q : x_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (state_q == S_DONE && out_free)
				out_valid_q <= 1'b1;
			else if (out_valid_q && !out_stall)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				n_q   <= candidate;
				nm1_q <= candidate - 1'b1;
				d_q   <= candidate - 1'b1;
				s_q   <= '0;
				k_q   <= '0;
				res_q <= (candidate >= 63'd2);
			end
			S_SPLIT: begin
				if (!d_q[0]) begin
					d_q <= {1'b0, d_q[CW-1:1]};
					s_q <= s_q + 1'b1;
				end
			end
			S_BASE: b_q <= {{(CW-6){1'b0}}, base_of(k_q)};
			S_RED: begin
				if (b_q >= n_q) begin
					b_q <= b_q - n_q;
				end else begin
					x_q   <= 63'd1;
					dsh_q <= d_q;
					bit_q <= '0;
				end
			end
			S_SQ_W: begin
				if (mul_done) begin
					x_q <= mul_res;
					if (!dsh_q[CW-1]) begin
						dsh_q <= {dsh_q[CW-2:0], 1'b0};
						bit_q <= bit_q + 1'b1;
					end
				end
			end
			S_ML_W: begin
				if (mul_done) begin
					x_q   <= mul_res;
					dsh_q <= {dsh_q[CW-2:0], 1'b0};
					bit_q <= bit_q + 1'b1;
				end
			end
			S_CHECK: begin
				i_q <= 6'd1;
				if (!chk_pass && !chk_more) res_q <= 1'b0;
			end
			S_SQR_W: begin
				if (mul_done) begin
					x_q <= mul_res;
					i_q <= i_q + 1'b1;
					if (!sqr_pass && !sqr_more) res_q <= 1'b0;
				end
			end
			S_THRESH: begin
				k_q <= k_q + 1'b1;
				if (th_fail) res_q <= 1'b0;
			end
			S_DONE: if (out_free) prime_flag_q <= res_q;
			default: ;
		endcase
	end

	assign out_valid  = out_valid_q;
	assign prime_flag = prime_flag_q;

`ifndef SYNTHESIS
	a_mul_wait: assert property (@(posedge clk) disable iff (!arst_n)
		mul_done |-> (state_q == S_SQ_W || state_q == S_ML_W || state_q == S_SQR_W))
		else $error("multiplier finished outside a wait state");
	a_x_reduced: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CHECK) |-> (x_q < n_q)) else $error("power not reduced");
	a_deliver: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE && out_free) |=> (out_valid && state_q == S_IDLE))
		else $error("result not delivered");
	a_base_idx: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_BASE) |-> (k_q <= LAST_BASE)) else $error("base index overrun");
`endif

endmodule

/* test/deterministic_miller_rabin_64_test.sv */
// deterministic_miller_rabin_64_test: self-checking bench for the 63-bit primality tester
// depends on dmr_pkg and deterministic_miller_rabin_64; predicts each flag with exact modular math
module deterministic_miller_rabin_64_test
	import dmr_pkg::*;
();

	localparam longint CYCLE_LIMIT = 200000000;

	typedef struct {
		logic [CW-1:0] cand;
		bit            drain;
	} request_t;

	logic          clk = 0;
	logic          arst_n = 0;
	logic          in_valid = 0;
	logic          in_stall;
	logic [CW-1:0] candidate = '0;
	logic          out_valid;
	logic          out_stall = 1;
	logic          prime_flag;

	request_t pending_q[$];
	bit       flag_q[$];
	int       errors = 0;
	int       gap = 0;
	int       hold = 2000;
	longint   cycles = 0;

	deterministic_miller_rabin_64 i_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .candidate(candidate),
		.out_valid(out_valid), .out_stall(out_stall), .prime_flag(prime_flag)
	);

	always #10 clk = ~clk;

	function automatic logic [CW-1:0] mul_mod(logic [CW-1:0] a, logic [CW-1:0] b,
			logic [CW-1:0] n);
		logic [127:0] p;
		p = 128'(a) * 128'(b);
		return CW'(p % 128'(n));
	endfunction

	function automatic logic [CW-1:0] pow_mod(logic [CW-1:0] b, logic [CW-1:0] e,
			logic [CW-1:0] n);
		logic [CW-1:0] r;
		r = CW'(1);
		b = b % n;
		while (e != 0) begin
			if (e[0]) r = mul_mod(r, b, n);
			b = mul_mod(b, b, n);
			e = e >> 1;
		end
		return r;
	endfunction

	function automatic bit strong_round(logic [CW-1:0] n, logic [CW-1:0] base);
		logic [CW-1:0] d;
		logic [CW-1:0] x;
		int s;
		d = n - 1;
		s = 0;
		while (!d[0]) begin
			d = d >> 1;
			s++;
		end
		x = pow_mod(base, d, n);
		if (x == 1 || x == n - 1) return 1;
		for (int i = 1; i < s; i++) begin
			x = mul_mod(x, x, n);
			if (x == n - 1) return 1;
		end
		return 0;
	endfunction

	function automatic bit prime_check(logic [CW-1:0] n);
		int bases [12] = '{2, 3, 5, 7, 11, 13, 17, 19, 23, 29, 31, 37};
		if (n < 2) return 0;
		if (n < 4) return 1;
		for (int k = 0; k < 12; k++) begin
			if (!strong_round(n, CW'(bases[k]))) return 0;
			case (k)
				1: if (n < LIM_B3) return 1;
				2: if (n < LIM_B5) return 1;
				3: begin
					if (n == PSP_B7) return 0;
					if (n < LIM_B7) return 1;
				end
				4: if (n < LIM_B11) return 1;
				5: if (n < LIM_B13) return 1;
				6: if (n < LIM_B17) return 1;
				default: ;
			endcase
		end
		return 1;
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 9);
		if (r < 6) return 0;
		if (r < 9) return $urandom_range(1, 4);
		return $urandom_range(20, 200);
	endfunction

	task automatic report(string what, logic [CW-1:0] got, logic [CW-1:0] want);
		$display("mismatch: %s got %0d expected %0d", what, got, want);
		errors++;
	endtask

	task automatic add(logic [CW-1:0] c, bit drain = 0);
		request_t r;
		r.cand = c;
		r.drain = drain;
		pending_q.push_back(r);
	endtask

	// sender
	bit       fire;
	request_t nxt;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 0;
			candidate <= '0;
		end else begin
			fire = in_valid && !in_stall;
			if (fire) flag_q.push_back(prime_check(candidate));
			if (!in_valid || fire) begin
				if (gap > 0) begin
					gap <= gap - 1;
					in_valid <= 0;
				end else if (pending_q.size() > 0 &&
						!(pending_q[0].drain && flag_q.size() > 0)) begin
					nxt = pending_q.pop_front();
					candidate <= nxt.cand;
					in_valid <= 1;
					gap <= pick_gap();
				end else begin
					in_valid <= 0;
				end
			end
		end
	end

	// receiver
	bit want;
	int r;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1;
		end else begin
			if (out_valid && !out_stall) begin
				if (flag_q.size() == 0) begin
					report("unexpected result", CW'(prime_flag), '0);
				end else begin
					want = flag_q.pop_front();
					if (prime_flag !== want) report("prime_flag", CW'(prime_flag), CW'(want));
				end
			end
			if (hold > 0) begin
				hold <= hold - 1;
				out_stall <= 1;
			end else begin
				r = $urandom_range(0, 19);
				if (r < 14) out_stall <= 0;
				else if (r < 19) out_stall <= 1;
				else begin
					hold <= $urandom_range(20, 200);
					out_stall <= 1;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	initial begin
		logic [CW-1:0] v;
		int sel;
		// short ones first so the block backs up behind the initial receiver hold-off
		add(0); add(1); add(2); add(3); add(4); add(3); add(2); add(0);
		add(561); add(97);
		add(63'd1373653); add(63'd25326001); add(PSP_B7); add(63'd2152302898747);
		add(63'd3474749660383); add(63'd341550071728321);
		add(63'd3825123056546413051);
		add(63'h7FFF_FFFF_FFFF_FFFF); add(63'h7FFF_FFFF_FFFF_FFFE);
		add(63'd9223372036854775783);
		add(63'd4294967291); add(63'd999999937, 1);
		for (int i = 0; i < 118; i++) begin
			sel = $urandom_range(0, 9);
			if (sel < 4) v = CW'($urandom_range(0, 1000));
			else if (sel < 7) v = CW'($urandom_range(0, 2097151));
			else if (sel < 8) v = {23'($urandom), 32'($urandom)} & 63'hFF_FFFF_FFFF;
			else v = {31'($urandom), 32'($urandom)};
			add(v, i == 70);
		end
		repeat (4) @(posedge clk);
		@(negedge clk) arst_n = 1;
		while (pending_q.size() > 0 || in_valid || flag_q.size() > 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (errors == 0) $display("simulation ok");
		else $display("simulation failed");
		$finish;
	end

endmodule
